[rtl/dibit_light_frame_transmitter_top_defines.svh]
// assertion macros used by the checker file
`ifndef DIBIT_LIGHT_FRAME_TRANSMITTER_TOP_DEFINES_SVH
`define DIBIT_LIGHT_FRAME_TRANSMITTER_TOP_DEFINES_SVH

// clocked assertion, off while reset is high
`define DLFT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also covers the reset cycles
`define DLFT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dlft_pkg.sv]
package dlft_pkg;

  localparam int PAYLOAD_LEN = 15;
  localparam int FRAME_LAST  = PAYLOAD_LEN + 2;
  localparam int POS_W       = $clog2(FRAME_LAST + 1);
  localparam int IDX_W       = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
  localparam int BYTE_W      = 8;
  localparam int BIDX_W      = 4;
  localparam int REG_IDX_W   = 1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_START_FIRST  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_START_SECOND = 1'b1;

  localparam logic [BYTE_W-1:0] START_FIRST_RST  = 8'd149;
  localparam logic [BYTE_W-1:0] START_SECOND_RST = 8'd27;

  localparam logic [1:0] SYM_LAST = 2'd3;

  typedef struct packed {
    logic              en;
    logic [BIDX_W-1:0] idx;
    logic [BYTE_W-1:0] value;
  } store_wr_t;

endpackage

[rtl/dlft_frame_store.sv]
module dlft_frame_store (
  input  logic                        clk,
  input  logic                        rst,
  input  dlft_pkg::store_wr_t         wr,
  input  logic [dlft_pkg::POS_W-1:0]  pos,
  input  logic [dlft_pkg::BYTE_W-1:0] start_first,
  input  logic [dlft_pkg::BYTE_W-1:0] start_second,
  output logic [dlft_pkg::BYTE_W-1:0] frame_byte
);

  logic [dlft_pkg::BYTE_W-1:0] store      [dlft_pkg::PAYLOAD_LEN];
  logic [dlft_pkg::BYTE_W-1:0] store_next [dlft_pkg::PAYLOAD_LEN];
  logic [dlft_pkg::BYTE_W-1:0] csum;
  logic [dlft_pkg::BYTE_W-1:0] csum_next;
  logic [dlft_pkg::POS_W-1:0]  rd_off;

  // checksum is rebuilt from the updated store so it always matches it
  always_comb begin
    store_next = store;
    csum_next  = '0;
    for (int i = 0; i < dlft_pkg::PAYLOAD_LEN; i++) begin
      if (int'(wr.idx) == i) begin
        store_next[i] = wr.value;
      end
    end
    for (int i = 0; i < dlft_pkg::PAYLOAD_LEN; i++) begin
      csum_next = csum_next ^ store_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dlft_pkg::PAYLOAD_LEN; i++) begin
        store[i] <= '0;
      end
      csum <= '0;
    end else if (wr.en) begin
      store <= store_next;
      csum  <= csum_next;
    end
  end

  assign rd_off = pos - dlft_pkg::POS_W'(2);

  always_comb begin
    if (pos == '0) begin
      frame_byte = start_first;
    end else if (pos == dlft_pkg::POS_W'(1)) begin
      frame_byte = start_second;
    end else if (rd_off < dlft_pkg::POS_W'(dlft_pkg::PAYLOAD_LEN)) begin
      frame_byte = store[rd_off[dlft_pkg::IDX_W-1:0]];
    end else begin
      frame_byte = csum;
    end
  end

endmodule

[rtl/dibit_light_frame_transmitter_top.sv]
// path: a tick beat passes the input register, then the result register, and waits in
// the input register while the held result is not taken; a load gives no result
// throughput: one beat per cycle while results are taken, set by the combinational frame byte select
// reset: synchronous, clears the payload store, checksum, frame and symbol position and
// both valid flags, and sets the start bytes back to their defaults
module dibit_light_frame_transmitter_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cmd,
  input  logic [dlft_pkg::BIDX_W-1:0]    byte_index,
  input  logic [dlft_pkg::BYTE_W-1:0]    byte_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           red_on,
  output logic                           blue_on,
  output logic                           frame_end,
  input  logic                           cfg_we,
  input  logic [dlft_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [dlft_pkg::BYTE_W-1:0]    cfg_data
);

  logic                          s1_valid;
  logic                          s1_cmd;
  logic [dlft_pkg::BIDX_W-1:0]   s1_idx;
  logic [dlft_pkg::BYTE_W-1:0]   s1_value;
  logic                          s1_go;
  logic                          tick_go;
  logic [dlft_pkg::POS_W-1:0]    frame_pos;
  logic [1:0]                    sym_pos;
  logic [dlft_pkg::BYTE_W-1:0]   start_first;
  logic [dlft_pkg::BYTE_W-1:0]   start_second;
  logic [dlft_pkg::BYTE_W-1:0]   frame_byte;
  logic [1:0]                    sym;
  logic                          at_last;
  dlft_pkg::store_wr_t           wr;

  assign s1_go    = s1_valid && ((s1_cmd == dlft_pkg::CMD_LOAD) || !out_valid || out_ready);
  assign tick_go  = s1_go && (s1_cmd == dlft_pkg::CMD_TICK);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_cmd   <= cmd;
      s1_idx   <= byte_index;
      s1_value <= byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_first  <= dlft_pkg::START_FIRST_RST;
      start_second <= dlft_pkg::START_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dlft_pkg::REG_START_FIRST:  start_first  <= cfg_data;
        dlft_pkg::REG_START_SECOND: start_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    wr.en    = s1_go && (s1_cmd == dlft_pkg::CMD_LOAD) &&
               (int'(s1_idx) < dlft_pkg::PAYLOAD_LEN);
    wr.idx   = s1_idx;
    wr.value = s1_value;
  end

  dlft_frame_store u_store (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .pos          (frame_pos),
    .start_first  (start_first),
    .start_second (start_second),
    .frame_byte   (frame_byte)
  );

  // most significant pair first
  always_comb begin
    case (sym_pos)
      2'd0:    sym = frame_byte[7:6];
      2'd1:    sym = frame_byte[5:4];
      2'd2:    sym = frame_byte[3:2];
      default: sym = frame_byte[1:0];
    endcase
  end

  assign at_last = (frame_pos == dlft_pkg::POS_W'(dlft_pkg::FRAME_LAST));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos <= '0;
      sym_pos   <= '0;
    end else if (tick_go) begin
      if (sym_pos == dlft_pkg::SYM_LAST) begin
        sym_pos   <= '0;
        frame_pos <= at_last ? '0 : frame_pos + dlft_pkg::POS_W'(1);
      end else begin
        sym_pos <= sym_pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      red_on    <= sym[1];
      blue_on   <= sym[0];
      frame_end <= at_last && (sym_pos == dlft_pkg::SYM_LAST);
    end
  end

endmodule

[rtl/dlft_checker.sv]
`include "dibit_light_frame_transmitter_top_defines.svh"

module dlft_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic red_on,
  input logic blue_on,
  input logic frame_end
);

  logic       last_end;
  logic [2:0] out_bits;

  assign out_bits = {red_on, blue_on, frame_end};

  // frame end seen on the previous result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      last_end <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_end <= frame_end;
    end
  end

  `DLFT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")
  `DLFT_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_bits), "stalled beat changed")
  `DLFT_ASSERT_RST(a_reset_idle, rst |=> !out_valid && in_ready, "not idle after reset")
  `DLFT_ASSERT(a_end_spacing, out_valid && last_end |-> !frame_end, "frame end twice in a row")

endmodule

bind dibit_light_frame_transmitter_top dlft_checker u_dlft_checker (.*);
